FILE: hw/rtl/hspt_pkg.sv
// hspt_pkg: shared types and codes for the open-addressed hash set
// no dependencies

package hspt_pkg;

    // per-slot mark held next to each key
    typedef logic [1:0] t_mark;

    localparam t_mark MARK_EMPTY   = 2'd0;
    localparam t_mark MARK_FILLED  = 2'd1;
    localparam t_mark MARK_DELETED = 2'd2;

    // request commands (any other code acts as find)
    typedef logic [1:0] t_cmd;

    localparam t_cmd CMD_ADD    = 2'd0;
    localparam t_cmd CMD_REMOVE = 2'd1;
    localparam t_cmd CMD_FIND   = 2'd2;

    // field widths
    localparam int unsigned KEY_W   = 32;
    localparam int unsigned HASH_W  = 32;
    localparam int unsigned SLOT_W  = 8;
    localparam int unsigned COUNT_W = 9;

    // stream payload widths, padded to whole bytes
    localparam int unsigned IN_DATA_W  = 72;
    localparam int unsigned OUT_DATA_W = 56;

endpackage

FILE: hw/rtl/hash_set_probing_tombstones.sv
// hash_set_probing_tombstones: open-addressed hash set with deleted marks,
// probed one slot at a time through a single registered-read slot memory
// depends on hspt_pkg

// Open-addressed hash set. Each input item carries a command (add, remove,
// find), a key and the key's hash. The home slot is the hash modulo
// TABLE_SLOTS (a power of two); probe k moves forward by k slots, so the
// offsets are triangular and every slot is visited once in TABLE_SLOTS
// probes. A probe stops on the key or on an empty slot; an add takes the
// first deleted slot on the path, else the empty slot that ended the probe.
// Each slot word {mark, key} lives in one memory with one write and one
// registered read port, and one sequencer reuses that port for every probe:
// an item takes from 1 up to TABLE_SLOTS probes, and each probe passes
// through an address state (S_READ) and a check state (S_EVAL).
// After reset the block sweeps the memory to mark all slots empty, one slot
// per cycle, so o_s_axis_tready stays low until the sweep is done. One result
// item is produced per input item; it sits in an output register, so the
// next input item is taken while the result waits.

module hash_set_probing_tombstones #(
    parameter int unsigned TABLE_SLOTS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // request stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [1:0] command, [33:2] key, [65:34] hash_value, [71:66] zero
    input  logic [hspt_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,

    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [0] found, [8:1] slot, [40:9] stored_key, [49:41] element_count,
    // [50] status, [55:51] zero
    output logic [hspt_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);

    localparam int unsigned IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int unsigned CNT_W = $clog2(TABLE_SLOTS + 1);
    localparam int unsigned MEM_W = hspt_pkg::KEY_W + 2;

    // sequencer states
    localparam logic [2:0] S_CLEAR = 3'd0;  // post-reset sweep
    localparam logic [2:0] S_IDLE  = 3'd1;  // waiting for a request
    localparam logic [2:0] S_READ  = 3'd2;  // address the probed slot
    localparam logic [2:0] S_EVAL  = 3'd3;  // check the slot word, finish or step

    logic [2:0]              r_state, n_state;
    logic [IDX_W-1:0]        r_clr_addr;

    // request held for the whole probe
    hspt_pkg::t_cmd          r_cmd;
    logic [hspt_pkg::KEY_W-1:0] r_key;

    // probe walk
    logic [IDX_W-1:0]        r_pos, n_pos;
    logic [IDX_W-1:0]        r_step;
    logic                    r_have_del;
    logic [IDX_W-1:0]        r_first_del;

    logic [CNT_W-1:0]        r_count;

    // slot memory: {mark, key}
    logic [MEM_W-1:0]        r_mem [TABLE_SLOTS];
    logic [MEM_W-1:0]        r_rd_data;

    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic [MEM_W-1:0]        wr_data;

    // result register
    logic                    r_out_valid;
    logic                    r_found;
    logic [IDX_W-1:0]        r_slot;
    logic [hspt_pkg::KEY_W-1:0] r_stored;
    logic                    r_status;

    // slot check
    hspt_pkg::t_mark         rd_mark;
    logic [hspt_pkg::KEY_W-1:0] rd_key;
    logic                    is_fill, is_del, is_hit, is_empty, last_step;
    logic                    done, out_free, finish;
    logic                    del_any;
    logic [IDX_W-1:0]        del_slot, chosen;
    logic                    table_full;

    // finish actions
    logic                    fin_status;
    logic [IDX_W-1:0]        fin_slot;
    logic [hspt_pkg::KEY_W-1:0] fin_stored;
    logic [CNT_W-1:0]        fin_count;

    assign o_s_axis_tready = (r_state == S_IDLE);

    assign rd_mark   = r_rd_data[MEM_W-1 -: 2];
    assign rd_key    = r_rd_data[hspt_pkg::KEY_W-1:0];
    assign is_fill   = (rd_mark == hspt_pkg::MARK_FILLED);
    assign is_del    = (rd_mark == hspt_pkg::MARK_DELETED);
    assign is_hit    = is_fill && (rd_key == r_key);
    // any mark that is neither filled nor deleted ends the probe as empty
    assign is_empty  = !is_fill && !is_del;
    assign last_step = (r_step == IDX_W'(TABLE_SLOTS - 1));
    assign done      = is_hit || is_empty || last_step;
    assign out_free  = !r_out_valid || i_m_axis_tready;
    assign finish    = (r_state == S_EVAL) && done && out_free;

    // first deleted slot on the path, counting the one under check
    assign del_any  = r_have_del || is_del;
    assign del_slot = r_have_del ? r_first_del : r_pos;
    assign chosen   = (!is_hit && del_any) ? del_slot : r_pos;

    assign table_full = (r_count >= CNT_W'(TABLE_SLOTS));

    // what the finished request does to the table and the count
    always_comb begin
        fin_status = 1'b0;
        fin_slot   = chosen;
        fin_stored = '0;
        fin_count  = r_count;
        wr_en      = 1'b0;
        wr_addr    = chosen;
        wr_data    = {hspt_pkg::MARK_FILLED, r_key};
        case (r_cmd)
            hspt_pkg::CMD_ADD: begin
                if (!is_hit) begin
                    if (table_full) begin
                        fin_status = 1'b1;
                        fin_slot   = '0;
                    end else begin
                        wr_en     = finish;
                        fin_count = CNT_W'(r_count + 1'b1);
                    end
                end
            end
            hspt_pkg::CMD_REMOVE: begin
                if (is_hit) begin
                    wr_en   = finish;
                    wr_data = {hspt_pkg::MARK_DELETED, r_key};
                    if (r_count != '0) begin
                        fin_count = CNT_W'(r_count - 1'b1);
                    end
                end
            end
            default: begin
                // find, and the unused code acting as find
                if (is_hit) begin
                    fin_stored = rd_key;
                end
            end
        endcase
        // the post-reset sweep owns the write port
        if (r_state == S_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = {hspt_pkg::MARK_EMPTY, hspt_pkg::KEY_W'(0)};
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == IDX_W'(TABLE_SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_state = S_READ;
                    // home slot
                    n_pos   = i_s_axis_tdata[34 +: IDX_W];
                end
            end
            S_READ: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (done) begin
                    if (out_free) begin
                        n_state = S_IDLE;
                    end
                end else begin
                    // next triangular step
                    n_state = S_READ;
                    n_pos   = IDX_W'(r_pos + r_step + 1'b1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= IDX_W'(r_clr_addr + 1'b1);
            end
            if (finish) begin
                r_count     <= fin_count;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request and probe registers
    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
        if (r_state == S_IDLE && i_s_axis_tvalid) begin
            r_cmd      <= i_s_axis_tdata[1:0];
            r_key      <= i_s_axis_tdata[2 +: hspt_pkg::KEY_W];
            r_step     <= '0;
            r_have_del <= 1'b0;
        end else if (r_state == S_EVAL && !done) begin
            r_step <= IDX_W'(r_step + 1'b1);
            if (is_del && !r_have_del) begin
                r_have_del  <= 1'b1;
                r_first_del <= r_pos;
            end
        end
    end

    // slot memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (r_state == S_READ) begin
            r_rd_data <= r_mem[r_pos];
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_found  <= is_hit;
            r_slot   <= fin_slot;
            r_stored <= fin_stored;
            r_status <= fin_status;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'd0,
                              r_status,
                              hspt_pkg::COUNT_W'(r_count),
                              r_stored,
                              hspt_pkg::SLOT_W'(r_slot),
                              r_found};

endmodule

FILE: tb/sv/tb_hash_set_probing_tombstones.sv
// tb_hash_set_probing_tombstones: self-checking bench for the open-addressed hash set
// keeps its own slot table, predicts every result item and compares it field by field
// depends on hspt_pkg and hash_set_probing_tombstones
`timescale 1ns / 1ps

module tb_hash_set_probing_tombstones;

    localparam int unsigned TABLE_SLOTS = 256;
    // drain margin, sized for the longest single item with every slot probed
    localparam int unsigned DRAIN_CYCLES = 1 + 2 * TABLE_SLOTS + 16;
    localparam int unsigned PAD_IN_W = hspt_pkg::IN_DATA_W - 2 - hspt_pkg::KEY_W
                                       - hspt_pkg::HASH_W;

    // one result item, unpacked
    typedef struct packed {
        logic                         found;
        logic [hspt_pkg::SLOT_W-1:0]  slot;
        logic [hspt_pkg::KEY_W-1:0]   stored_key;
        logic [hspt_pkg::COUNT_W-1:0] element_count;
        logic                         status;
    } t_set_result;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_s_axis_tvalid;
    logic                            o_s_axis_tready;
    // [1:0] command, [33:2] key, [65:34] hash_value, [71:66] zero
    logic [hspt_pkg::IN_DATA_W-1:0]  i_s_axis_tdata;
    logic                            o_m_axis_tvalid;
    logic                            i_m_axis_tready;
    // [0] found, [8:1] slot, [40:9] stored_key, [49:41] element_count, [50] status
    logic [hspt_pkg::OUT_DATA_W-1:0] o_m_axis_tdata;

    // shadow of the table as the block should hold it
    logic [hspt_pkg::KEY_W-1:0]  slot_key  [TABLE_SLOTS];
    logic [hspt_pkg::HASH_W-1:0] slot_hash [TABLE_SLOTS];  // hash used when the key went in
    hspt_pkg::t_mark             slot_mark [TABLE_SLOTS];
    int                          stored_count;

    t_set_result expected_results[$];
    int          mismatch_count;
    int          send_idle_pct;
    int          recv_idle_pct;

    hash_set_probing_tombstones #(
        .TABLE_SLOTS(TABLE_SLOTS)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // 4 ns period
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // probe the shadow table, apply the command and return the result item it gives
    function automatic t_set_result apply_request(input hspt_pkg::t_cmd cmd,
                                                  input logic [hspt_pkg::KEY_W-1:0] key,
                                                  input logic [hspt_pkg::HASH_W-1:0] hash);
        t_set_result res;
        int          pos;
        int          first_deleted;
        bit          hit;
        res = '0;
        hit = 1'b0;
        first_deleted = -1;
        pos = int'(hash % TABLE_SLOTS);
        // triangular probing: hop k moves k slots past the previous one
        for (int hop = 0; hop < TABLE_SLOTS; hop++) begin
            pos = (pos + hop) % TABLE_SLOTS;
            if (slot_mark[pos] == hspt_pkg::MARK_FILLED) begin
                if (slot_key[pos] == key) begin
                    hit = 1'b1;
                    break;
                end
            end else if (slot_mark[pos] == hspt_pkg::MARK_DELETED) begin
                if (first_deleted < 0)
                    first_deleted = pos;
            end else begin
                break;
            end
        end
        // a miss reports the first tombstone on the path, if there was one
        if (!hit && first_deleted >= 0)
            pos = first_deleted;
        case (cmd)
            hspt_pkg::CMD_ADD: begin
                if (!hit) begin
                    if (stored_count >= TABLE_SLOTS) begin
                        // table full: refused, slot reads zero
                        res.status = 1'b1;
                        pos = 0;
                    end else begin
                        slot_key[pos]  = key;
                        slot_hash[pos] = hash;
                        slot_mark[pos] = hspt_pkg::MARK_FILLED;
                        stored_count++;
                    end
                end
            end
            hspt_pkg::CMD_REMOVE: begin
                if (hit) begin
                    slot_mark[pos] = hspt_pkg::MARK_DELETED;
                    if (stored_count > 0)
                        stored_count--;
                end
            end
            default: begin
                // find, and the unused code which behaves as find
                if (hit)
                    res.stored_key = slot_key[pos];
            end
        endcase
        res.found = hit;
        res.slot = pos[hspt_pkg::SLOT_W-1:0];
        res.element_count = stored_count[hspt_pkg::COUNT_W-1:0];
        return res;
    endfunction

    // random filled slot, scanning from a random start; 0 when the table is empty
    function automatic bit pick_filled_slot(output int slot_idx);
        int start_idx;
        start_idx = $urandom_range(TABLE_SLOTS - 1);
        slot_idx = 0;
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            if (slot_mark[(start_idx + i) % TABLE_SLOTS] == hspt_pkg::MARK_FILLED) begin
                slot_idx = (start_idx + i) % TABLE_SLOTS;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // random hash; half of them land on a few crowded home slots to build long chains
    function automatic logic [hspt_pkg::HASH_W-1:0] pick_hash();
        logic [hspt_pkg::HASH_W-1:0] h;
        logic [7:0]                  hot_homes [4];
        hot_homes = '{8'h00, 8'h10, 8'hFE, 8'hFF};
        h = $urandom;
        if ($urandom_range(1) == 1)
            h[7:0] = hot_homes[$urandom_range(3)];
        return h;
    endfunction

    function automatic void check_field(input string name,
                                        input logic [hspt_pkg::KEY_W-1:0] want,
                                        input logic [hspt_pkg::KEY_W-1:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    // offer one request item, wait for it to be taken, then record what it must return
    task automatic send_request(input hspt_pkg::t_cmd cmd,
                                input logic [hspt_pkg::KEY_W-1:0] key,
                                input logic [hspt_pkg::HASH_W-1:0] hash);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {{PAD_IN_W{1'b0}}, hash, key, cmd};
        do @(posedge i_clk); while (!o_s_axis_tready);
        expected_results.push_back(apply_request(cmd, key, hash));
    endtask

    // result side: random back-pressure and a field-by-field check of each item
    always @(posedge i_clk) begin
        t_set_result want;
        t_set_result got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.found         = o_m_axis_tdata[0];
            got.slot          = o_m_axis_tdata[8:1];
            got.stored_key    = o_m_axis_tdata[40:9];
            got.element_count = o_m_axis_tdata[49:41];
            got.status        = o_m_axis_tdata[50];
            if (expected_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: result with none expected: expected nothing, actual %0h",
                         $time, o_m_axis_tdata);
            end else begin
                want = expected_results.pop_front();
                check_field("found", want.found, got.found);
                check_field("slot", want.slot, got.slot);
                check_field("stored_key", want.stored_key, got.stored_key);
                check_field("element_count", want.element_count, got.element_count);
                check_field("status", want.status, got.status);
            end
        end
        i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // field extremes, every command, collisions, tombstone reuse and wrap-around
    task automatic test_directed();
        // empty table: misses report the home slot
        send_request(hspt_pkg::CMD_FIND, 32'h0000_0000, 32'h0000_0000);
        send_request(hspt_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(hspt_pkg::CMD_ADD, 32'h0000_0000, 32'h0000_0000);
        send_request(hspt_pkg::CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // add of a present key changes nothing
        send_request(hspt_pkg::CMD_ADD, 32'h0000_0000, 32'h0000_0000);
        send_request(hspt_pkg::CMD_FIND, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // unused command code behaves as find
        send_request(hspt_pkg::t_cmd'(2'd3), 32'h0000_0000, 32'h0000_0000);
        // home slot 255 and 0 taken: probe wraps past the top of the table
        send_request(hspt_pkg::CMD_ADD, 32'h5A5A_A5A5, 32'h8000_00FF);
        // chain of three keys on home slot 0x10, hashes differ above the index bits
        send_request(hspt_pkg::CMD_ADD, 32'h1111_0001, 32'hABCD_0010);
        send_request(hspt_pkg::CMD_ADD, 32'h2222_0002, 32'h1234_5610);
        send_request(hspt_pkg::CMD_ADD, 32'h3333_0003, 32'hFFFF_FF10);
        // two tombstones at the head of the chain
        send_request(hspt_pkg::CMD_REMOVE, 32'h1111_0001, 32'hABCD_0010);
        send_request(hspt_pkg::CMD_REMOVE, 32'h2222_0002, 32'h1234_5610);
        // find walks past tombstones to the live key
        send_request(hspt_pkg::CMD_FIND, 32'h3333_0003, 32'hFFFF_FF10);
        // miss through tombstones reports the first one
        send_request(hspt_pkg::CMD_FIND, 32'h4444_0004, 32'h0000_0010);
        send_request(hspt_pkg::CMD_REMOVE, 32'h4444_0004, 32'h0000_0010);
        // adds reuse the first tombstone, then the next
        send_request(hspt_pkg::CMD_ADD, 32'h4444_0004, 32'h0000_0010);
        send_request(hspt_pkg::CMD_ADD, 32'h1111_0001, 32'hABCD_0010);
        send_request(hspt_pkg::t_cmd'(2'd3), 32'h3333_0003, 32'hFFFF_FF10);
        send_request(hspt_pkg::CMD_REMOVE, 32'h3333_0003, 32'hFFFF_FF10);
        send_request(hspt_pkg::CMD_FIND, 32'h3333_0003, 32'hFFFF_FF10);
    endtask

    // mostly well-formed traffic on keys the table holds, with misses and noise mixed in
    task automatic test_random_mix(input int num_items);
        int                         sel;
        int                         add_pct;
        int                         idx;
        logic [hspt_pkg::KEY_W-1:0] new_key;
        for (int n = 0; n < num_items; n++) begin
            sel = $urandom_range(99);
            // ease off adds once the table is well loaded
            add_pct = (stored_count < 160) ? 45 : 20;
            new_key = $urandom;
            if (sel < add_pct) begin
                send_request(hspt_pkg::CMD_ADD, new_key, pick_hash());
            end else if (sel < add_pct + 43 && pick_filled_slot(idx)) begin
                // hit on a stored key with its own hash
                sel = $urandom_range(99);
                if (sel < 40)
                    send_request(hspt_pkg::CMD_FIND, slot_key[idx], slot_hash[idx]);
                else if (sel < 75)
                    send_request(hspt_pkg::CMD_REMOVE, slot_key[idx], slot_hash[idx]);
                else if (sel < 88)
                    send_request(hspt_pkg::t_cmd'(2'd3), slot_key[idx], slot_hash[idx]);
                else
                    send_request(hspt_pkg::CMD_ADD, slot_key[idx], slot_hash[idx]);
            end else begin
                // misses and noise, never an add
                send_request(hspt_pkg::t_cmd'($urandom_range(1, 3)), new_key, pick_hash());
            end
        end
    endtask

    // fill every slot, then refused add, full-length probes and tombstone reuse
    task automatic test_full_table();
        int tries;
        int idx;
        tries = 0;
        while (stored_count < TABLE_SLOTS && tries < 4 * TABLE_SLOTS) begin
            send_request(hspt_pkg::CMD_ADD, $urandom, pick_hash());
            tries++;
        end
        // no empty slot left: misses probe the whole table
        send_request(hspt_pkg::CMD_ADD, $urandom, pick_hash());
        send_request(hspt_pkg::CMD_FIND, $urandom, pick_hash());
        send_request(hspt_pkg::CMD_REMOVE, $urandom, pick_hash());
        if (pick_filled_slot(idx))
            send_request(hspt_pkg::CMD_FIND, slot_key[idx], slot_hash[idx]);
        for (int i = 0; i < 3; i++) begin
            if (pick_filled_slot(idx))
                send_request(hspt_pkg::CMD_REMOVE, slot_key[idx], slot_hash[idx]);
        end
        // only tombstones and filled slots: miss reports the first tombstone
        send_request(hspt_pkg::CMD_FIND, $urandom, pick_hash());
        send_request(hspt_pkg::CMD_ADD, $urandom, pick_hash());
        send_request(hspt_pkg::CMD_ADD, $urandom, pick_hash());
        send_request(hspt_pkg::CMD_ADD, $urandom, pick_hash());
        send_request(hspt_pkg::CMD_ADD, $urandom, pick_hash());
    endtask

    initial begin
        foreach (slot_mark[i]) begin
            slot_mark[i] = hspt_pkg::MARK_EMPTY;
            slot_key[i]  = '0;
            slot_hash[i] = '0;
        end
        stored_count    = 0;
        mismatch_count  = 0;
        send_idle_pct   = 35;
        recv_idle_pct   = 81;
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // the clearing sweep after reset holds tready low; send_request waits it out

        test_directed();
        test_random_mix(180);

        send_idle_pct = 81;
        recv_idle_pct = 35;
        test_random_mix(180);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_mix(180);
        test_full_table();

        i_s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/hspt_pkg.sv
hw/rtl/hash_set_probing_tombstones.sv
tb/sv/tb_hash_set_probing_tombstones.sv
